// ===== design/pbrq_pkg.sv =====
// shared types, constants and codes for the box range query table
package pbrq_pkg;

	localparam int MAX_ENTRIES_DEF = 256;
	localparam int MATCH_LIMIT_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;

	localparam int COORD_W  = 24;
	localparam int DIST_W   = 23;
	localparam int ID_W     = 32;
	localparam int PIDX_W   = 8;
	localparam int STATUS_W = 3;
	localparam int DIFF_W   = COORD_W + 2;

	localparam logic [STATUS_W-1:0] ST_ADDED    = 3'd0;
	localparam logic [STATUS_W-1:0] ST_MATCH    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NOMATCH  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BADINDEX = 3'd4;

	typedef enum logic [1:0] {
		K_ADD,
		K_FULL,
		K_BAD,
		K_QUERY
	} cmd_kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_CENTRE,
		B_SCAN,
		B_FINISH
	} back_state_t;

	typedef struct packed {
		cmd_kind_t           kind;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic                use_given;
		logic [PIDX_W-1:0]   pidx;
		logic [DIST_W-1:0]   reach;
		logic [ID_W-1:0]     ident;
	} cmd_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [ID_W-1:0]    ident;
	} entry_t;

endpackage

// ===== design/pbrq_front.sv =====
// front end: accepts input transactions, tracks the fill count and classifies each one
module pbrq_front #(
	parameter int MAX_ENTRIES = pbrq_pkg::MAX_ENTRIES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              func,
	input  logic signed [pbrq_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pbrq_pkg::COORD_W-1:0] coord_y,
	input  logic                              use_given_centre,
	input  logic [pbrq_pkg::PIDX_W-1:0]       player_index,
	input  logic [pbrq_pkg::DIST_W-1:0]       distance,
	input  logic [pbrq_pkg::ID_W-1:0]         identity,
	output logic                              q_valid,
	input  logic                              q_stall,
	output pbrq_pkg::cmd_t                    q_cmd
);
	import pbrq_pkg::*;

	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > PIDX_W) ? CNT_W : PIDX_W;

	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             is_full;
	logic             bad_idx;

	assign in_stall = q_stall;
	assign q_valid  = in_valid;
	assign accept   = in_valid && !q_stall;
	assign is_full  = (count_q == CNT_W'(MAX_ENTRIES));
	assign bad_idx  = (CMP_W'(player_index) >= CMP_W'(count_q));

	always_comb begin
		q_cmd.x         = coord_x;
		q_cmd.y         = coord_y;
		q_cmd.use_given = use_given_centre;
		q_cmd.pidx      = player_index;
		q_cmd.reach     = distance;
		q_cmd.ident     = identity;
		if (!func) begin
			q_cmd.kind = is_full ? K_FULL : K_ADD;
		end else begin
			q_cmd.kind = bad_idx ? K_BAD : K_QUERY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && !func && !is_full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

endmodule

// ===== design/pbrq_queue.sv =====
// short command queue between front end and back end
module pbrq_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_stall,
	input  pbrq_pkg::cmd_t push_data,
	output logic           pop_valid,
	input  logic           pop_stall,
	output pbrq_pkg::cmd_t pop_data
);
	import pbrq_pkg::*;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t              entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign push_stall = (fill_q == FILL_W'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_valid && !pop_stall;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

// ===== design/pbrq_back.sv =====
// back end: entry table, ordered box scan and result register
module pbrq_back #(
	parameter int MAX_ENTRIES = pbrq_pkg::MAX_ENTRIES_DEF,
	parameter int MATCH_LIMIT = pbrq_pkg::MATCH_LIMIT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  pbrq_pkg::cmd_t                cmd,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pbrq_pkg::STATUS_W-1:0] status,
	output logic [pbrq_pkg::PIDX_W-1:0]   entry_index,
	output logic [pbrq_pkg::ID_W-1:0]     entry_identity,
	output logic                          last
);
	import pbrq_pkg::*;

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int MC_W  = $clog2(MATCH_LIMIT + 1);
	localparam int CMP_W = (IDX_W > PIDX_W) ? IDX_W : PIDX_W;

	back_state_t        state_q;
	back_state_t        state_nxt;

	entry_t             mem_q [MAX_ENTRIES];
	entry_t             rdata_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               valid_s1;

	logic [CNT_W-1:0]   wcnt_q;
	cmd_t               cur_q;
	logic [COORD_W-1:0] cx_q;
	logic [COORD_W-1:0] cy_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic [MC_W-1:0]    mcnt_q;
	logic               pend_valid_q;
	logic [IDX_W-1:0]   pend_idx_q;
	logic [ID_W-1:0]    pend_id_q;

	logic               out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [PIDX_W-1:0]  index_q;
	logic [ID_W-1:0]    ident_q;
	logic               last_q;

	logic               out_free;
	logic               take;
	logic               wr_en;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic               in_x;
	logic               in_y;
	logic               hit;
	logic               advance;
	logic               issue;
	logic               push;
	logic [STATUS_W-1:0] res_status;
	logic [PIDX_W-1:0]  res_index;
	logic [ID_W-1:0]    res_ident;
	logic               res_last;

	logic signed [DIFF_W-1:0] dx;
	logic signed [DIFF_W-1:0] dy;
	logic signed [DIFF_W-1:0] dlim;

	assign out_free = !out_valid_q || !out_stall;

	assign dx   = $signed({{2{cx_q[COORD_W-1]}}, cx_q})
		- $signed({{2{rdata_s1.x[COORD_W-1]}}, rdata_s1.x});
	assign dy   = $signed({{2{cy_q[COORD_W-1]}}, cy_q})
		- $signed({{2{rdata_s1.y[COORD_W-1]}}, rdata_s1.y});
	assign dlim = $signed({3'b000, cur_q.reach});
	assign in_x = (dx < dlim) && (dx > -dlim);
	assign in_y = (dy < dlim) && (dy > -dlim);

	// control outputs per state
	always_comb begin
		take       = 1'b0;
		cmd_stall  = 1'b1;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = rd_idx_q[IDX_W-1:0];
		hit        = 1'b0;
		advance    = 1'b1;
		issue      = 1'b0;
		push       = 1'b0;
		res_status = ST_ADDED;
		res_index  = '0;
		res_ident  = '0;
		res_last   = 1'b1;
		case (state_q)
			B_IDLE: begin
				cmd_stall = !(cmd.kind == K_QUERY || out_free);
				take      = cmd_valid && !cmd_stall;
				case (cmd.kind)
					K_ADD: begin
						push       = take;
						wr_en      = take;
						res_status = ST_ADDED;
						res_index  = PIDX_W'(wcnt_q);
					end
					K_FULL: begin
						push       = take;
						res_status = ST_FULL;
					end
					K_BAD: begin
						push       = take;
						res_status = ST_BADINDEX;
					end
					K_QUERY: begin
						rd_en   = take && !cmd.use_given;
						rd_addr = IDX_W'(cmd.pidx);
					end
					default: begin
						push = 1'b0;
					end
				endcase
			end
			B_SCAN: begin
				hit = valid_s1 && (mcnt_q != MC_W'(MATCH_LIMIT))
					&& (CMP_W'(idx_s1) != CMP_W'(cur_q.pidx)) && in_x && in_y;
				advance    = !(hit && pend_valid_q && !out_free);
				issue      = (rd_idx_q < wcnt_q) && (mcnt_q != MC_W'(MATCH_LIMIT));
				rd_en      = advance;
				push       = hit && pend_valid_q && advance;
				res_status = ST_MATCH;
				res_index  = PIDX_W'(pend_idx_q);
				res_ident  = pend_id_q;
				res_last   = 1'b0;
			end
			B_FINISH: begin
				push       = out_free;
				res_status = pend_valid_q ? ST_MATCH : ST_NOMATCH;
				res_index  = pend_valid_q ? PIDX_W'(pend_idx_q) : '0;
				res_ident  = pend_valid_q ? pend_id_q : '0;
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			B_IDLE: begin
				if (take && cmd.kind == K_QUERY) begin
					state_nxt = cmd.use_given ? B_SCAN : B_CENTRE;
				end
			end
			B_CENTRE: begin
				state_nxt = B_SCAN;
			end
			B_SCAN: begin
				if (!valid_s1 && !issue) begin
					state_nxt = B_FINISH;
				end
			end
			B_FINISH: begin
				if (out_free) begin
					state_nxt = B_IDLE;
				end
			end
			default: begin
				state_nxt = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wcnt_q[IDX_W-1:0]] <= '{x: cmd.x, y: cmd.y, ident: cmd.ident};
		end
		if (rd_en) begin
			rdata_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (take && cmd.kind == K_QUERY) begin
			cur_q <= cmd;
			cx_q  <= cmd.x;
			cy_q  <= cmd.y;
		end else if (state_q == B_CENTRE) begin
			cx_q <= rdata_s1.x;
			cy_q <= rdata_s1.y;
		end
		if (state_q == B_SCAN && advance && issue) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (hit && advance) begin
			pend_idx_q <= idx_s1;
			pend_id_q  <= rdata_s1.ident;
		end
		if (push) begin
			status_q <= res_status;
			index_q  <= res_index;
			ident_q  <= res_ident;
			last_q   <= res_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			wcnt_q       <= '0;
			rd_idx_q     <= '0;
			mcnt_q       <= '0;
			pend_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (wr_en) begin
				wcnt_q <= wcnt_q + CNT_W'(1);
			end
			if (state_q == B_SCAN) begin
				if (advance) begin
					valid_s1 <= issue;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
				end
				if (hit && advance) begin
					mcnt_q       <= mcnt_q + MC_W'(1);
					pend_valid_q <= 1'b1;
				end
			end else begin
				valid_s1 <= 1'b0;
				if (state_q != B_FINISH) begin
					rd_idx_q     <= '0;
					mcnt_q       <= '0;
					pend_valid_q <= 1'b0;
				end
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign entry_index    = index_q;
	assign entry_identity = ident_q;
	assign last           = last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		mcnt_q <= MC_W'(MATCH_LIMIT))
		else $error("match count beyond limit");

	assert property (@(posedge clk) disable iff (!arst_n)
		wcnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("table count beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (CNT_W'(idx_s1) < wcnt_q))
		else $error("scan read beyond filled entries");

	assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (mcnt_q != '0))
		else $error("held match without match count");

	assert property (@(posedge clk) disable iff (!arst_n)
		(push && state_q == B_SCAN) |-> pend_valid_q && hit)
		else $error("scan result pushed without held match");

endmodule

// ===== design/player_box_range_query_table.sv =====
// top level of the box range query table
// Stores up to MAX_ENTRIES (x, y, identity) entries in one MAX_ENTRIES x 80-bit single-port
// table, filled in order by add transactions; table contents are undefined after reset and
// only the fill count is cleared, so no clearing pass is needed. Add, table-full and bad-index
// transactions give one result each. A range query scans the filled entries in index order,
// one table read per cycle while no held match waits on a stalled output; when the centre is
// fetched from a stored entry, a centre state comes before the scan, and the scan ends early
// once MATCH_LIMIT matches are found. A two-entry command queue lets new transactions be
// accepted while a query runs.
module player_box_range_query_table #(
	parameter int MAX_ENTRIES = pbrq_pkg::MAX_ENTRIES_DEF,
	parameter int MATCH_LIMIT = pbrq_pkg::MATCH_LIMIT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                func,
	input  logic signed [pbrq_pkg::COORD_W-1:0] coord_x,
	input  logic signed [pbrq_pkg::COORD_W-1:0] coord_y,
	input  logic                                use_given_centre,
	input  logic [pbrq_pkg::PIDX_W-1:0]         player_index,
	input  logic [pbrq_pkg::DIST_W-1:0]         distance,
	input  logic [pbrq_pkg::ID_W-1:0]           identity,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pbrq_pkg::STATUS_W-1:0]       status,
	output logic [pbrq_pkg::PIDX_W-1:0]         entry_index,
	output logic [pbrq_pkg::ID_W-1:0]           entry_identity,
	output logic                                last
);
	import pbrq_pkg::*;

	logic q_push_valid;
	logic q_push_stall;
	cmd_t q_push_cmd;
	logic q_pop_valid;
	logic q_pop_stall;
	cmd_t q_pop_cmd;

	pbrq_front #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.use_given_centre (use_given_centre),
		.player_index     (player_index),
		.distance         (distance),
		.identity         (identity),
		.q_valid          (q_push_valid),
		.q_stall          (q_push_stall),
		.q_cmd            (q_push_cmd)
	);

	pbrq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push_valid),
		.push_stall (q_push_stall),
		.push_data  (q_push_cmd),
		.pop_valid  (q_pop_valid),
		.pop_stall  (q_pop_stall),
		.pop_data   (q_pop_cmd)
	);

	pbrq_back #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.MATCH_LIMIT(MATCH_LIMIT)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (q_pop_valid),
		.cmd_stall      (q_pop_stall),
		.cmd            (q_pop_cmd),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.entry_index    (entry_index),
		.entry_identity (entry_identity),
		.last           (last)
	);

endmodule

// ===== tb/tb_player_box_range_query_table.sv =====
// testbench for the box range query table: random add and query traffic checked against a mirror
`timescale 1ns / 100ps
module tb_player_box_range_query_table;
	import pbrq_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int RANDOM_ITEMS = 380;
	localparam int DRAIN_CYCLES = 300;
	localparam int MAX_WAIT     = 15;
	localparam int SHOWN_ERRORS = 10;
	localparam int COORD_MAX    = (1 << (COORD_W - 1)) - 1;
	localparam int COORD_MIN    = -(1 << (COORD_W - 1));
	localparam int DIST_MAX     = (1 << DIST_W) - 1;

	localparam logic FUNC_ADD   = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct {
		logic                      func;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic                      use_given;
		logic [PIDX_W-1:0]         pidx;
		logic [DIST_W-1:0]         reach;
		logic [ID_W-1:0]           ident;
	} command_t;

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [PIDX_W-1:0]   index;
		logic [ID_W-1:0]     ident;
		logic                last;
	} reply_t;

	class box_table_mirror;
		logic signed [COORD_W-1:0] x_tab [MAX_ENTRIES_DEF];
		logic signed [COORD_W-1:0] y_tab [MAX_ENTRIES_DEF];
		logic [ID_W-1:0]           id_tab [MAX_ENTRIES_DEF];
		int                        fill;
		int                        errors;
		reply_t                    pending [$];

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function void push_reply(logic [STATUS_W-1:0] st, int idx, logic [ID_W-1:0] id,
				logic fin);
			reply_t r;
			r.status = st;
			r.index = idx[PIDX_W-1:0];
			r.ident = id;
			r.last = fin;
			pending.push_back(r);
		endfunction

		function bit in_open_span(longint c, longint p, longint d);
			return c > p - d && c < p + d;
		endfunction

		// work out every reply of one accepted transaction
		function void accept_command(command_t c);
			longint cx;
			longint cy;
			longint d;
			int hits;
			if (c.func == FUNC_ADD) begin
				if (fill >= MAX_ENTRIES_DEF) begin
					push_reply(ST_FULL, 0, '0, 1'b1);
				end else begin
					x_tab[fill] = c.x;
					y_tab[fill] = c.y;
					id_tab[fill] = c.ident;
					push_reply(ST_ADDED, fill, '0, 1'b1);
					fill++;
				end
				return;
			end
			if (int'(c.pidx) >= fill) begin
				push_reply(ST_BADINDEX, 0, '0, 1'b1);
				return;
			end
			cx = c.use_given ? longint'(c.x) : longint'(x_tab[c.pidx]);
			cy = c.use_given ? longint'(c.y) : longint'(y_tab[c.pidx]);
			d = longint'(c.reach);
			hits = 0;
			for (int i = 0; i < fill && hits < MATCH_LIMIT_DEF; i++) begin
				if (i != int'(c.pidx) && in_open_span(cx, x_tab[i], d) &&
						in_open_span(cy, y_tab[i], d)) begin
					push_reply(ST_MATCH, i, id_tab[i], 1'b0);
					hits++;
				end
			end
			if (hits == 0)
				push_reply(ST_NOMATCH, 0, '0, 1'b1);
			else
				pending[pending.size() - 1].last = 1'b1;
		endfunction

		function void compare_reply(reply_t got);
			reply_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display("unexpected result: status %0d index %0d identity %h last %0d",
						got.status, got.index, got.ident, got.last);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.index !== want.index ||
					got.ident !== want.ident || got.last !== want.last) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display({"mismatch: expected status %0d index %0d identity %h last %0d,",
						" got status %0d index %0d identity %h last %0d"},
						want.status, want.index, want.ident, want.last,
						got.status, got.index, got.ident, got.last);
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_stall;
	logic                      func;
	logic signed [COORD_W-1:0] coord_x;
	logic signed [COORD_W-1:0] coord_y;
	logic                      use_given_centre;
	logic [PIDX_W-1:0]         player_index;
	logic [DIST_W-1:0]         distance;
	logic [ID_W-1:0]           identity;
	logic                      out_valid;
	logic                      out_stall;
	logic [STATUS_W-1:0]       status;
	logic [PIDX_W-1:0]         entry_index;
	logic [ID_W-1:0]           entry_identity;
	logic                      last;

	box_table_mirror mirror = new();
	int              cycle_count = 0;
	bit              send_calm = 1'b0;
	bit              take_calm = 1'b0;

	player_box_range_query_table dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.func             (func),
		.coord_x          (coord_x),
		.coord_y          (coord_y),
		.use_given_centre (use_given_centre),
		.player_index     (player_index),
		.distance         (distance),
		.identity         (identity),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.entry_index      (entry_index),
		.entry_identity   (entry_identity),
		.last             (last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_player_box_range_query_table failed");
			$finish;
		end
	end

	function automatic logic signed [COORD_W-1:0] near(int base);
		int v;
		v = base + int'($urandom_range(0, 2048)) - 1024;
		if (v > COORD_MAX)
			v = COORD_MAX;
		if (v < COORD_MIN)
			v = COORD_MIN;
		return v[COORD_W-1:0];
	endfunction

	// points gather around a few hot spots, two of them at the corners of the range
	function automatic void random_point(output logic signed [COORD_W-1:0] px,
			output logic signed [COORD_W-1:0] py);
		case ($urandom_range(0, 3))
			0: begin
				px = near(0);
				py = near(0);
			end
			1: begin
				px = near(1000000);
				py = near(-2000000);
			end
			2: begin
				px = near(COORD_MAX - 300);
				py = near(COORD_MIN + 300);
			end
			default: begin
				px = near(COORD_MIN + 300);
				py = near(COORD_MAX - 300);
			end
		endcase
	endfunction

	function automatic command_t noise_command();
		command_t c;
		c.func = FUNC_ADD;
		c.x = COORD_W'($urandom);
		c.y = COORD_W'($urandom);
		c.use_given = 1'($urandom_range(0, 1));
		c.pidx = PIDX_W'($urandom);
		c.reach = DIST_W'($urandom);
		c.ident = $urandom;
		return c;
	endfunction

	task automatic send_command(input command_t c);
		int gap;
		if ($urandom_range(0, 15) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= c.func;
		coord_x <= c.x;
		coord_y <= c.y;
		use_given_centre <= c.use_given;
		player_index <= c.pidx;
		distance <= c.reach;
		identity <= c.ident;
		do @(posedge clk); while (in_stall);
		mirror.accept_command(c);
	endtask

	task automatic add_at(input int x, input int y, input logic [ID_W-1:0] id);
		command_t c;
		c = noise_command();
		c.func = FUNC_ADD;
		c.x = x[COORD_W-1:0];
		c.y = y[COORD_W-1:0];
		c.ident = id;
		send_command(c);
	endtask

	task automatic query_at(input logic given, input int x, input int y, input int idx,
			input int reach);
		command_t c;
		c = noise_command();
		c.func = FUNC_QUERY;
		c.use_given = given;
		c.x = x[COORD_W-1:0];
		c.y = y[COORD_W-1:0];
		c.pidx = idx[PIDX_W-1:0];
		c.reach = reach[DIST_W-1:0];
		send_command(c);
	endtask

	// result side: after every result taken, draw a random stall length, zero in calm phases
	initial begin
		int hold;
		reply_t got;
		hold = 0;
		out_stall <= 1'b1;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.status = status;
				got.index = entry_index;
				got.ident = entry_identity;
				got.last = last;
				mirror.compare_reply(got);
				if ($urandom_range(0, 15) == 0)
					take_calm = !take_calm;
				hold = take_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				hold--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		command_t c;
		int roll;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		func <= FUNC_ADD;
		coord_x <= '0;
		coord_y <= '0;
		use_given_centre <= 1'b0;
		player_index <= '0;
		distance <= '0;
		identity <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// queries on an empty table
		query_at(1'b1, 0, 0, 0, 100);
		query_at(1'b0, 0, 0, 255, DIST_MAX);
		// corners and near-origin entries
		add_at(COORD_MIN, COORD_MIN, 32'h0000_0000);
		add_at(COORD_MAX, COORD_MAX, 32'hFFFF_FFFF);
		add_at(0, 0, 32'h1234_5678);
		add_at(COORD_MAX, COORD_MIN, 32'h8000_0001);
		add_at(COORD_MIN, COORD_MAX, 32'h7FFF_FFFE);
		add_at(1, -1, 32'hA5A5_5A5A);
		query_at(1'b0, 0, 0, 0, DIST_MAX);
		query_at(1'b0, 0, 0, 1, DIST_MAX);
		query_at(1'b1, 0, 0, 2, DIST_MAX);
		query_at(1'b1, 0, 0, 7, DIST_MAX);
		query_at(1'b1, 0, 0, 6, 1000);
		query_at(1'b0, 0, 0, 6, 1000);
		query_at(1'b1, 1, -1, 0, 0);
		query_at(1'b1, 0, 0, 0, 2);
		query_at(1'b1, 0, 0, 0, 1);
		query_at(1'b1, COORD_MAX, COORD_MIN, 5, DIST_MAX);
		query_at(1'b0, 0, 0, 5, 3);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			c = noise_command();
			roll = $urandom_range(0, 99);
			if (mirror.fill < MAX_ENTRIES_DEF ? roll < 72 : roll < 12) begin
				c.func = FUNC_ADD;
				if ($urandom_range(0, 4) != 0)
					random_point(c.x, c.y);
			end else begin
				c.func = FUNC_QUERY;
				if (mirror.fill == 0 || $urandom_range(0, 9) == 0) begin
					if (mirror.fill < MAX_ENTRIES_DEF)
						c.pidx = PIDX_W'($urandom_range(mirror.fill, 255));
				end else begin
					c.pidx = PIDX_W'($urandom_range(0, mirror.fill - 1));
				end
				if ($urandom_range(0, 4) != 0)
					random_point(c.x, c.y);
				case ($urandom_range(0, 9))
					0: c.reach = '0;
					1: c.reach = DIST_W'(DIST_MAX);
					2, 3, 4, 5: c.reach = DIST_W'($urandom_range(0, 3000));
					default: ;
				endcase
			end
			send_command(c);
		end

		// fill the table, run into the full case, then query the full table
		while (mirror.fill < MAX_ENTRIES_DEF) begin
			c = noise_command();
			random_point(c.x, c.y);
			send_command(c);
		end
		repeat (3) send_command(noise_command());
		repeat (4) begin
			c = noise_command();
			c.func = FUNC_QUERY;
			random_point(c.x, c.y);
			c.reach = DIST_W'($urandom_range(0, 4000));
			send_command(c);
		end
		in_valid <= 1'b0;

		while (mirror.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.errors == 0 && mirror.pending.size() == 0)
			$display("tb_player_box_range_query_table passed");
		else
			$display("tb_player_box_range_query_table failed");
		$finish;
	end

endmodule

// ===== player_box_range_query_table.f =====
design/pbrq_pkg.sv
design/pbrq_front.sv
design/pbrq_queue.sv
design/pbrq_back.sv
design/player_box_range_query_table.sv
tb/tb_player_box_range_query_table.sv
